>>> sv/svp_pkg.sv
// types, constants and character classes for the version string parser
// no dependencies; used by svp_parse_core and semver_string_parser
package svp_pkg;

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_PFXWS = 3'd1;
    localparam logic [2:0] PH_MAJOR = 3'd2;
    localparam logic [2:0] PH_MINOR = 3'd3;
    localparam logic [2:0] PH_PATCH = 3'd4;
    localparam logic [2:0] PH_PRE   = 3'd5;
    localparam logic [2:0] PH_BUILD = 3'd6;
    localparam logic [2:0] PH_TRAIL = 3'd7;

    localparam logic [7:0] CH_V_LO = 8'h76;
    localparam logic [7:0] CH_V_UP = 8'h56;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    // largest value that can still take one more digit
    localparam logic [63:0] NUM_GUARD = 64'd1844674407370955160;

    typedef struct packed {
        logic        valid_res;
        logic [63:0] major_num;
        logic [63:0] minor_num;
        logic [63:0] patch_num;
        logic [7:0]  pre_offset;
        logic [8:0]  pre_length;
        logic [7:0]  build_offset;
        logic [8:0]  build_length;
    } svp_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_prefix(input logic [7:0] c);
        return c inside {CH_V_LO, CH_V_UP, CH_EQ};
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_DASH};
    endfunction

endpackage

>>> sv/svp_parse_core.sv
// per-byte grammar state, number accumulation and end-of-string verdict
// depends on svp_pkg
module svp_parse_core
    import svp_pkg::*;
#(
    parameter int MAX_LEN = 256,
    localparam int POS_W = $clog2(MAX_LEN + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        loose_mode,
    input  logic        take,
    input  logic [7:0]  char_byte,
    input  logic        end_of_string,
    output svp_result_t result
);

    logic [2:0]       phase_reg, phase_next;
    logic [63:0]      acc_reg, acc_next;
    logic             digits_reg, digits_next;
    logic             lzero_reg, lzero_next;
    logic [63:0]      major_reg, major_next;
    logic [63:0]      minor_reg, minor_next;
    logic [63:0]      patch_reg, patch_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       pre_start_reg, pre_start_next;
    logic [POS_W-1:0] pre_len_reg, pre_len_next;
    logic [7:0]       bld_start_reg, bld_start_next;
    logic [POS_W-1:0] bld_len_reg, bld_len_next;
    logic             pdot_reg, pdot_next;
    logic             failed_reg, failed_next;

    logic [POS_W-1:0] pos_p1;
    logic [POS_W+7:0] pos_p1_ext;
    logic [3:0]       digit;
    logic             do_digit;
    logic             ok;
    logic [POS_W+8:0] pre_len_ext, bld_len_ext;

    assign pos_p1     = pos_reg + POS_W'(1);
    assign pos_p1_ext = {8'b0, pos_p1};
    assign digit      = char_byte[3:0];

    always_comb begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        digits_next    = digits_reg;
        lzero_next     = lzero_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        patch_next     = patch_reg;
        pos_next       = pos_reg;
        pre_start_next = pre_start_reg;
        pre_len_next   = pre_len_reg;
        bld_start_next = bld_start_reg;
        bld_len_next   = bld_len_reg;
        pdot_next      = pdot_reg;
        failed_next    = failed_reg;
        do_digit       = 1'b0;

        if (!failed_reg) begin
            if (pos_reg >= POS_W'(MAX_LEN)) begin
                failed_next = 1'b1;
            end else begin
                pos_next = pos_p1;
                case (phase_reg)
                    PH_LEAD: begin
                        if (loose_mode && is_space(char_byte)) begin
                        end else if (loose_mode && is_prefix(char_byte)) begin
                            phase_next = PH_PFXWS;
                        end else if (is_digit(char_byte)) begin
                            phase_next = PH_MAJOR;
                            do_digit   = 1'b1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_PFXWS: begin
                        if (is_space(char_byte)) begin
                        end else if (is_digit(char_byte)) begin
                            phase_next = PH_MAJOR;
                            do_digit   = 1'b1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_MAJOR, PH_MINOR: begin
                        if (is_digit(char_byte)) begin
                            do_digit = 1'b1;
                        end else if (char_byte == CH_DOT && digits_reg) begin
                            if (phase_reg == PH_MAJOR) begin
                                major_next = acc_reg;
                            end else begin
                                minor_next = acc_reg;
                            end
                            acc_next    = '0;
                            digits_next = 1'b0;
                            lzero_next  = 1'b0;
                            phase_next  = phase_reg + 3'd1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_PATCH: begin
                        if (is_digit(char_byte)) begin
                            do_digit = 1'b1;
                        end else if (!digits_reg) begin
                            failed_next = 1'b1;
                        end else begin
                            patch_next  = acc_reg;
                            acc_next    = '0;
                            digits_next = 1'b0;
                            lzero_next  = 1'b0;
                            if (char_byte == CH_DASH) begin
                                phase_next     = PH_PRE;
                                pre_start_next = pos_p1_ext[7:0];
                                pdot_next      = 1'b0;
                            end else if (char_byte == CH_PLUS) begin
                                phase_next     = PH_BUILD;
                                bld_start_next = pos_p1_ext[7:0];
                                pdot_next      = 1'b0;
                            end else if (loose_mode && is_space(char_byte)) begin
                                phase_next = PH_TRAIL;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_PRE: begin
                        if (char_byte == CH_PLUS) begin
                            if (pre_len_reg == '0 || pdot_reg) begin
                                failed_next = 1'b1;
                            end else begin
                                phase_next     = PH_BUILD;
                                bld_start_next = pos_p1_ext[7:0];
                                pdot_next      = 1'b0;
                            end
                        end else if (char_byte == CH_DOT) begin
                            if (pre_len_reg == '0 || pdot_reg) begin
                                failed_next = 1'b1;
                            end else begin
                                pdot_next    = 1'b1;
                                pre_len_next = pre_len_reg + POS_W'(1);
                            end
                        end else if (is_ident(char_byte)) begin
                            pdot_next    = 1'b0;
                            pre_len_next = pre_len_reg + POS_W'(1);
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_BUILD: begin
                        if (char_byte == CH_DOT) begin
                            if (bld_len_reg == '0 || pdot_reg) begin
                                failed_next = 1'b1;
                            end else begin
                                pdot_next    = 1'b1;
                                bld_len_next = bld_len_reg + POS_W'(1);
                            end
                        end else if (is_ident(char_byte)) begin
                            pdot_next    = 1'b0;
                            bld_len_next = bld_len_reg + POS_W'(1);
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_TRAIL: begin
                        if (!is_space(char_byte)) begin
                            failed_next = 1'b1;
                        end
                    end
                    default: begin
                        failed_next = 1'b1;
                    end
                endcase

                if (do_digit) begin
                    if (digits_reg && lzero_reg) begin
                        failed_next = 1'b1;
                    end else if (acc_reg > NUM_GUARD) begin
                        failed_next = 1'b1;
                    end else begin
                        // times ten as two shifts and an add
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + 64'(digit);
                        if (!digits_reg) begin
                            digits_next = 1'b1;
                            lzero_next  = (digit == 4'd0);
                        end
                    end
                end
            end
        end
    end

    // verdict on the state after this word
    always_comb begin
        case (phase_next)
            PH_PATCH: ok = digits_next;
            PH_PRE:   ok = (pre_len_next != '0) && !pdot_next;
            PH_BUILD: ok = (bld_len_next != '0) && !pdot_next;
            PH_TRAIL: ok = 1'b1;
            default:  ok = 1'b0;
        endcase
        ok = ok && !failed_next;
    end

    assign pre_len_ext = {9'b0, pre_len_next};
    assign bld_len_ext = {9'b0, bld_len_next};

    always_comb begin
        result.valid_res    = ok;
        result.major_num    = ok ? major_next : '0;
        result.minor_num    = ok ? minor_next : '0;
        result.patch_num    = ok ? ((phase_next == PH_PATCH) ? acc_next : patch_next) : '0;
        result.pre_offset   = (ok && pre_len_next != '0) ? pre_start_next : '0;
        result.pre_length   = ok ? pre_len_ext[8:0] : '0;
        result.build_offset = (ok && bld_len_next != '0) ? bld_start_next : '0;
        result.build_length = ok ? bld_len_ext[8:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && end_of_string)) begin
            phase_reg     <= PH_LEAD;
            acc_reg       <= '0;
            digits_reg    <= 1'b0;
            lzero_reg     <= 1'b0;
            major_reg     <= '0;
            minor_reg     <= '0;
            patch_reg     <= '0;
            pos_reg       <= '0;
            pre_start_reg <= '0;
            pre_len_reg   <= '0;
            bld_start_reg <= '0;
            bld_len_reg   <= '0;
            pdot_reg      <= 1'b0;
            failed_reg    <= 1'b0;
        end else if (take) begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            digits_reg    <= digits_next;
            lzero_reg     <= lzero_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            patch_reg     <= patch_next;
            pos_reg       <= pos_next;
            pre_start_reg <= pre_start_next;
            pre_len_reg   <= pre_len_next;
            bld_start_reg <= bld_start_next;
            bld_len_reg   <= bld_len_next;
            pdot_reg      <= pdot_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

>>> sv/semver_string_parser.sv
// top level of the version string parser: config register, input handshake,
// two-entry result buffer; depends on svp_pkg and svp_parse_core
//
// The parser takes one byte of a MAJOR.MINOR.PATCH[-PRE][+BUILD] string per
// cycle, with s_end_of_string on the last byte, and stores one result word in
// the result buffer when it is taken. Every byte is handled in the cycle
// it is accepted, so the sustained rate is one byte per cycle; the only stall
// is when both entries of the result buffer are full (s_ready low until the
// sink takes a word). Strings longer than MAX_LEN bytes are reported invalid.
// cfg_we/cfg_wdata write loose_mode and must only be used between strings.
module semver_string_parser
    import svp_pkg::*;
#(
    parameter int MAX_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [63:0] m_major_num,
    output logic [63:0] m_minor_num,
    output logic [63:0] m_patch_num,
    output logic [7:0]  m_pre_offset,
    output logic [8:0]  m_pre_length,
    output logic [7:0]  m_build_offset,
    output logic [8:0]  m_build_length
);

    logic        loose_reg;
    logic        take, push, pop;
    svp_result_t core_res;
    svp_result_t out_reg, out_next, skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loose_reg <= 1'b0;
        end else if (cfg_we) begin
            loose_reg <= cfg_wdata;
        end
    end

    assign s_ready = !skid_valid_reg;
    assign take    = s_valid && s_ready;
    assign push    = take && s_end_of_string;
    assign pop     = out_valid_reg && m_ready;

    svp_parse_core #(
        .MAX_LEN(MAX_LEN)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .loose_mode    (loose_reg),
        .take          (take),
        .char_byte     (s_char_byte),
        .end_of_string (s_end_of_string),
        .result        (core_res)
    );

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            out_next        = skid_reg;
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (!out_valid_next) begin
                out_next       = core_res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = core_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_valid_res    = out_reg.valid_res;
    assign m_major_num    = out_reg.major_num;
    assign m_minor_num    = out_reg.minor_num;
    assign m_patch_num    = out_reg.patch_num;
    assign m_pre_offset   = out_reg.pre_offset;
    assign m_pre_length   = out_reg.pre_length;
    assign m_build_offset = out_reg.build_offset;
    assign m_build_length = out_reg.build_length;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output entry empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid entry filled without a stalled output");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_major_num == 64'd0 && m_pre_length == 9'd0
            && m_build_length == 9'd0 && m_patch_num == 64'd0))
        else $error("invalid result word carries nonzero fields");

endmodule

>>> tb/tb_semver_string_parser.sv
// self-checking testbench for semver_string_parser: directed and random version
// strings against a built-in parse predictor; depends on svp_pkg and the rtl top
module tb_semver_string_parser;
    import svp_pkg::*;

    localparam int    CYCLE_LIMIT  = 300000;
    localparam int    RANDOM_BYTES = 300;
    localparam int    DRAIN_CYCLES = 8;
    localparam int    STRING_LIMIT = 256;
    localparam string IDENT_CHARS  =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-";

    typedef logic [7:0] text_t[$];

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_byte = 8'h00;
    logic        s_end_of_string = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_valid_res;
    logic [63:0] m_major_num;
    logic [63:0] m_minor_num;
    logic [63:0] m_patch_num;
    logic [7:0]  m_pre_offset;
    logic [8:0]  m_pre_length;
    logic [7:0]  m_build_offset;
    logic [8:0]  m_build_length;

    semver_string_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_byte     (s_char_byte),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_major_num     (m_major_num),
        .m_minor_num     (m_minor_num),
        .m_patch_num     (m_patch_num),
        .m_pre_offset    (m_pre_offset),
        .m_pre_length    (m_pre_length),
        .m_build_offset  (m_build_offset),
        .m_build_length  (m_build_length)
    );

    char_word_t  send_q[$];
    svp_result_t parse_expect_q[$];
    text_t       draft;
    char_word_t  next_word;
    svp_result_t oldest;
    logic        byte_taken = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int unsigned sink_tick = 0;
    int          cycle_count = 0;
    int          err_count = 0;
    int          random_bytes = 0;

    // predictor state
    logic        loose_cfg;
    logic [2:0]  ph;
    logic [63:0] acc, maj_v, min_v, pat_v;
    logic        have_digit, lead_zero, dot_prev, broken;
    logic [8:0]  pos, pre_len, bld_len;
    logic [7:0]  pre_at, bld_at;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic num_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic ident_char(input logic [7:0] c);
        return num_char(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
            || c == CH_DASH;
    endfunction

    task automatic clear_parse_state();
        ph = PH_LEAD;
        acc = '0;
        have_digit = 1'b0;
        lead_zero = 1'b0;
        maj_v = '0;
        min_v = '0;
        pat_v = '0;
        pos = '0;
        pre_at = '0;
        pre_len = '0;
        bld_at = '0;
        bld_len = '0;
        dot_prev = 1'b0;
        broken = 1'b0;
    endtask

    task automatic add_digit(input logic [3:0] d);
        if (have_digit && lead_zero) begin
            broken = 1'b1;
        end else if (acc > NUM_GUARD) begin
            broken = 1'b1;
        end else begin
            acc = acc * 64'd10 + 64'(d);
            if (!have_digit) begin
                have_digit = 1'b1;
                lead_zero = (d == 4'd0);
            end
        end
    endtask

    task automatic seal_number(inout logic [63:0] dst, output logic ok);
        ok = have_digit;
        if (have_digit) begin
            dst = acc;
            acc = '0;
            have_digit = 1'b0;
            lead_zero = 1'b0;
        end
    endtask

    task automatic span_char(input logic [7:0] c, inout logic [8:0] len);
        if (c == CH_DOT && (len == 0 || dot_prev)) begin
            broken = 1'b1;
        end else if (c != CH_DOT && !ident_char(c)) begin
            broken = 1'b1;
        end else begin
            dot_prev = (c == CH_DOT);
            len = len + 9'd1;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic ok;
        case (ph)
            PH_LEAD: begin
                if (loose_cfg && blank_char(c)) begin
                end else if (loose_cfg && (c == CH_V_LO || c == CH_V_UP || c == CH_EQ)) begin
                    ph = PH_PFXWS;
                end else if (num_char(c)) begin
                    ph = PH_MAJOR;
                    add_digit(c[3:0]);
                end else begin
                    broken = 1'b1;
                end
            end
            PH_PFXWS: begin
                if (blank_char(c)) begin
                end else if (num_char(c)) begin
                    ph = PH_MAJOR;
                    add_digit(c[3:0]);
                end else begin
                    broken = 1'b1;
                end
            end
            PH_MAJOR, PH_MINOR: begin
                if (num_char(c)) begin
                    add_digit(c[3:0]);
                end else if (c == CH_DOT) begin
                    if (ph == PH_MAJOR) seal_number(maj_v, ok);
                    else seal_number(min_v, ok);
                    if (!ok) broken = 1'b1;
                    else ph = (ph == PH_MAJOR) ? PH_MINOR : PH_PATCH;
                end else begin
                    broken = 1'b1;
                end
            end
            PH_PATCH: begin
                if (num_char(c)) begin
                    add_digit(c[3:0]);
                end else begin
                    seal_number(pat_v, ok);
                    if (!ok) begin
                        broken = 1'b1;
                    end else if (c == CH_DASH) begin
                        ph = PH_PRE;
                        pre_at = 8'(pos + 9'd1);
                        dot_prev = 1'b0;
                    end else if (c == CH_PLUS) begin
                        ph = PH_BUILD;
                        bld_at = 8'(pos + 9'd1);
                        dot_prev = 1'b0;
                    end else if (loose_cfg && blank_char(c)) begin
                        ph = PH_TRAIL;
                    end else begin
                        broken = 1'b1;
                    end
                end
            end
            PH_PRE: begin
                if (c == CH_PLUS) begin
                    if (pre_len == 0 || dot_prev) begin
                        broken = 1'b1;
                    end else begin
                        ph = PH_BUILD;
                        bld_at = 8'(pos + 9'd1);
                        dot_prev = 1'b0;
                    end
                end else begin
                    span_char(c, pre_len);
                end
            end
            PH_BUILD: span_char(c, bld_len);
            PH_TRAIL: if (!blank_char(c)) broken = 1'b1;
            default: broken = 1'b1;
        endcase
    endtask

    task automatic accept_byte(input logic [7:0] c, input logic last);
        svp_result_t r;
        logic ok;
        if (!broken) begin
            if (pos >= STRING_LIMIT) begin
                broken = 1'b1;
            end else begin
                parse_char(c);
                pos = pos + 9'd1;
            end
        end
        if (last) begin
            ok = 1'b0;
            if (!broken) begin
                case (ph)
                    PH_PATCH: seal_number(pat_v, ok);
                    PH_PRE:   ok = (pre_len != 0) && !dot_prev;
                    PH_BUILD: ok = (bld_len != 0) && !dot_prev;
                    PH_TRAIL: ok = 1'b1;
                    default:  ok = 1'b0;
                endcase
            end
            r = '0;
            r.valid_res = ok;
            if (ok) begin
                r.major_num = maj_v;
                r.minor_num = min_v;
                r.patch_num = pat_v;
                r.pre_offset = (pre_len != 0) ? pre_at : 8'd0;
                r.pre_length = pre_len;
                r.build_offset = (bld_len != 0) ? bld_at : 8'd0;
                r.build_length = bld_len;
            end
            parse_expect_q.insert(parse_expect_q.size(), r);
            clear_parse_state();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // input acceptance and result checking
    always @(posedge aclk) begin
        byte_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) accept_byte(s_char_byte, s_end_of_string);
        if (aresetn && m_valid && m_ready) begin
            if (parse_expect_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual valid_res %0d",
                         $time, m_valid_res);
                err_count++;
            end else begin
                oldest = parse_expect_q.pop_front();
                check_field("valid_res", 64'(oldest.valid_res), 64'(m_valid_res));
                check_field("major_num", oldest.major_num, m_major_num);
                check_field("minor_num", oldest.minor_num, m_minor_num);
                check_field("patch_num", oldest.patch_num, m_patch_num);
                check_field("pre_offset", 64'(oldest.pre_offset), 64'(m_pre_offset));
                check_field("pre_length", 64'(oldest.pre_length), 64'(m_pre_length));
                check_field("build_offset", 64'(oldest.build_offset), 64'(m_build_offset));
                check_field("build_length", 64'(oldest.build_length), 64'(m_build_length));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("semver_string_parser regression: fail");
            $finish;
        end
    end

    // byte driver, bursts with gaps
    always @(negedge aclk) begin
        if (!s_valid || byte_taken) begin
            if (!aresetn || send_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else begin
                next_word = send_q.pop_front();
                s_valid <= 1'b1;
                s_char_byte <= next_word.ch;
                s_end_of_string <= next_word.last;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                             : $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    // result sink stall pattern
    always @(negedge aclk) begin
        sink_tick++;
        if (hold_req && !hold_done) begin
            hold_left = 200;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (sink_tick[8:7])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= 1'($urandom_range(0, 1));
                2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (sink_tick[2:0] != 3'd0);
            endcase
        end
    end

    task automatic put_byte(input logic [7:0] b);
        draft.insert(draft.size(), b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic queue_draft();
        char_word_t w;
        for (int i = 0; i < draft.size(); i++) begin
            w.ch = draft[i];
            w.last = (i == draft.size() - 1);
            send_q.insert(send_q.size(), w);
        end
    endtask

    task automatic send_text(input string s);
        draft.delete();
        put_str(s);
        queue_draft();
    endtask

    task automatic put_ws_run();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: put_byte(8'h20);
                1: put_byte(8'h09);
                2: put_byte(8'h0A);
                3: put_byte(8'h0B);
                4: put_byte(8'h0C);
                default: put_byte(8'h0D);
            endcase
        end
    endtask

    task automatic put_number();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0: ;
            1: begin
                put_str("0");
                put_str($sformatf("%0d", $urandom_range(0, 99)));
            end
            2: put_str($sformatf("%0d", wide));
            3: put_str($sformatf("%0d", wide >> $urandom_range(1, 63)));
            4: begin
                // around the overflow guard
                put_str("184467440737095516");
                put_str($sformatf("%0d%0d", $urandom_range(0, 1), $urandom_range(0, 9)));
            end
            5: put_str("18446744073709551615");
            default: put_str($sformatf("%0d", $urandom_range(0, 999)));
        endcase
    endtask

    task automatic put_span();
        int n;
        int r;
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n) begin
            r = $urandom_range(0, 39);
            if (r < 5) put_byte(CH_DOT);
            else if (r == 5) put_byte(8'($urandom_range(0, 255)));
            else put_byte(IDENT_CHARS[$urandom_range(0, IDENT_CHARS.len() - 1)]);
        end
    endtask

    task automatic make_version(input logic lenient);
        int r;
        draft.delete();
        r = $urandom_range(0, 19);
        if (r == 0) begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
        end else begin
            if (lenient && $urandom_range(0, 2) == 0) put_ws_run();
            if ((lenient && $urandom_range(0, 2) == 0) || r == 1) begin
                case ($urandom_range(0, 2))
                    0: put_byte(CH_V_LO);
                    1: put_byte(CH_V_UP);
                    default: put_byte(CH_EQ);
                endcase
                if ($urandom_range(0, 1) == 1) put_ws_run();
            end
            put_number();
            put_byte(CH_DOT);
            put_number();
            put_byte(CH_DOT);
            put_number();
            r = $urandom_range(0, 3);
            if (r[0]) begin
                put_byte(CH_DASH);
                put_span();
            end
            if (r[1]) begin
                put_byte(CH_PLUS);
                put_span();
            end
            if (lenient && $urandom_range(0, 3) == 0) put_ws_run();
            if ($urandom_range(0, 9) == 0)
                draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic wait_idle();
        while (send_q.size() != 0 || s_valid || parse_expect_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_loose(input logic mode);
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wdata <= mode;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        loose_cfg = mode;
        @(posedge aclk);
    endtask

    task automatic run_random_phase(input logic mode, input int target, input logic squeeze);
        int taken;
        set_loose(mode);
        if (squeeze) hold_req = 1'b1;
        taken = 0;
        while (taken < target) begin
            make_version(mode || ($urandom_range(0, 7) == 0));
            taken += draft.size();
            queue_draft();
        end
        random_bytes += taken;
    endtask

    task automatic put_ident_run(input int n);
        repeat (n) put_byte(IDENT_CHARS[$urandom_range(0, IDENT_CHARS.len() - 1)]);
    endtask

    initial begin
        logic mode;
        loose_cfg = 1'b0;
        clear_parse_state();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_loose(1'b0);
        send_text("0.0.0");
        send_text("1.0.0-0.3.7+Z-9.x");
        send_text("18446744073709551609.0.0");
        send_text("18446744073709551610.1.1");
        send_text("01.2.3");
        send_text("1..3");
        send_text("1.2");
        send_text("1.2.3-");
        send_text("1.2.3+");
        send_text("1.2.3-.a");
        send_text("1.2.3-a..b");
        send_text("1.2.3-a.+b");
        send_text("1.2.3+b.");
        send_text("v1.2.3");
        send_text(" 1.2.3");
        send_text("1.2.3 ");
        send_text("1.2.3-a_b");
        draft.delete();
        put_byte(8'hFF);
        queue_draft();
        draft.delete();
        put_byte(8'h00);
        put_byte(8'h80);
        queue_draft();

        set_loose(1'b1);
        send_text(" \t v\015 1.2.3 \015\n");
        send_text("=1.2.3");
        send_text("V\v1.0.0-rc.1");
        send_text("\f1.2.3-a ");
        send_text("1.2.3+b  ");
        send_text("vv1.2.3");
        send_text("  ");
        send_text("1.2.3 x");
        send_text("= 2.3.4+meta");

        // sink held off while strings keep coming
        run_random_phase(1'b1, 200, 1'b1);
        mode = 1'b0;
        while (random_bytes < RANDOM_BYTES) begin
            run_random_phase(mode, 150, 1'b0);
            mode = ~mode;
        end

        // longest accepted string, then one byte too many
        set_loose(1'b0);
        draft.delete();
        put_str("0.0.0-");
        put_ident_run(140);
        put_byte(CH_PLUS);
        put_ident_run(STRING_LIMIT - 147);
        queue_draft();
        draft.delete();
        put_str("7.8.9+");
        put_ident_run(STRING_LIMIT - 5);
        queue_draft();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && parse_expect_q.size() == 0) begin
            $display("semver_string_parser regression: pass");
        end else begin
            $display("semver_string_parser regression: fail");
        end
        $finish;
    end

endmodule
